[hdl/cursor_hash_table_engine_core_assert.svh]
// Assertion helpers shared by the hash table engine modules.
`ifndef CURSOR_HASH_TABLE_ENGINE_CORE_ASSERT_SVH
`define CURSOR_HASH_TABLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cht_pkg.sv]
package cht_pkg;

  localparam int KEY_W  = 15;
  localparam int SLOT_W = 5;
  localparam int REQ_W  = 2;
  localparam int ST_W   = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_index;
  } out_word_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] home;
    logic             bad;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_SEND
  } front_state_e;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_IHOME,
    B_ICELL,
    B_IWALK,
    B_SCHK,
    B_DFREE,
    B_RESP
  } back_state_e;

endpackage

[hdl/cursor_hash_table_engine_core.sv]
// Hash set of three-letter keys (base-26, 15 bits) in a slot store of SLOTS
// cells: cells below BUCKETS are addressed by key mod BUCKETS, the rest form an
// overflow area kept on a free list and chained behind full buckets.
// Input words (req_type, key) enter on push_i while full_o is low; each word
// yields exactly one result word (status, slot_index), presented while empty_o
// is low and removed with pop_i.
// The front takes key mod BUCKETS by reciprocal multiply, subtract and one
// correction; each accepted word passes accept, 3 hash steps and hand-off,
// and the front takes no new word until it has handed off the last one.
// A two-entry queue feeds the back, which runs the slot store through one
// read port and one write port: a request with a bad bucket or unused code
// resolves without a store access, a search or delete reads the chain cell by
// cell from its home bucket (an overflow delete then pushes the freed cell on
// the free list), and an insert fills its home bucket or takes an overflow
// cell and walks the chain to its tail to link it there.
// After reset the back sweeps the store once, clearing valid marks and
// building the free list; full_o stays high during that sweep.
// When the receiver holds off pop_i, one result waits in the output register,
// the back stalls behind it, and the queue and front keep taking words until
// they fill.
module cursor_hash_table_engine_core #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  cht_pkg::in_word_t  in_word_i,
  output logic               empty_o,
  input  logic               pop_i,
  output cht_pkg::out_word_t out_word_o
);

  cht_pkg::cmd_t front_cmd, back_cmd;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty, init_busy;

  cht_front #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_word_i   (in_word_i),
    .init_busy_i (init_busy),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  cht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  cht_back #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_word_o  (out_word_o)
  );

endmodule

[hdl/cht_front.sv]
module cht_front #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  cht_pkg::in_word_t in_word_i,
  input  logic              init_busy_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output cht_pkg::cmd_t     cmd_o
);

  localparam int KW = cht_pkg::KEY_W;
  localparam int PW = 2 * KW;
  // Reciprocal of the bucket count scaled by 2^KW; the quotient it gives is at
  // most one short, so one compare and subtract finishes the remainder.
  localparam logic [KW-1:0] RECIP = KW'((2 ** KW) / BUCKETS);
  localparam logic [KW-1:0] BKT   = KW'(BUCKETS);

  cht_pkg::front_state_e state_q, state_d;
  logic [cht_pkg::REQ_W-1:0] req_q, req_d;
  logic [KW-1:0]             key_q, key_d;
  logic [KW-1:0]             rem_q, rem_d;
  logic [PW-1:0]             prod_q, prod_d;
  logic [1:0]                step_q, step_d;
  logic [KW-1:0]             quot, quot_bkt;

  assign quot     = prod_q[PW-1:KW];
  assign quot_bkt = quot * BKT;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    key_d      = key_q;
    rem_d      = rem_q;
    prod_d     = prod_q;
    step_d     = step_q;
    cmd_push_o = 1'b0;
    full_o     = 1'b1;
    case (state_q)
      cht_pkg::F_IDLE: begin
        full_o = init_busy_i;
        if (push_i && !init_busy_i) begin
          req_d   = in_word_i.req_type;
          key_d   = in_word_i.key;
          step_d  = 2'd0;
          state_d = cht_pkg::F_HASH;
        end
      end
      cht_pkg::F_HASH: begin
        // Multiply by the reciprocal, take the estimate off the key, then fix.
        if (step_q == 2'd0) begin
          prod_d = PW'(key_q) * PW'(RECIP);
          step_d = 2'd1;
        end else if (step_q == 2'd1) begin
          rem_d  = key_q - quot_bkt;
          step_d = 2'd2;
        end else begin
          if (rem_q >= BKT) begin
            rem_d = rem_q - BKT;
          end
          state_d = cht_pkg::F_SEND;
        end
      end
      cht_pkg::F_SEND: begin
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          state_d = cht_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::F_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.req  = req_q;
    cmd_o.key  = key_q;
    cmd_o.home = rem_q;
    // Unused code or a bucket past the store resolves without touching it.
    cmd_o.bad  = (req_q == cht_pkg::REQ_NOP) || (int'(rem_q) >= SLOTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    key_q  <= key_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    step_q <= step_d;
  end

  `include "cursor_hash_table_engine_core_assert.svh"

  `CHT_ASSERT_IMPL(a_home_range, clk_i, rst_ni, state_q == cht_pkg::F_SEND, rem_q < BKT, "bad home")
  `CHT_ASSERT_NEXT(a_accept_hash, clk_i, rst_ni, push_i && !full_o, state_q == cht_pkg::F_HASH, "no hash")

endmodule

[hdl/cht_fifo.sv]
module cht_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cht_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cht_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cht_pkg::cmd_t   buf_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  `include "cursor_hash_table_engine_core_assert.svh"

  `CHT_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "queue count overflow")

endmodule

[hdl/cht_back.sv]
module cht_back #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  cht_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               init_busy_o,
  output logic               empty_o,
  input  logic               pop_i,
  output cht_pkg::out_word_t out_word_o
);

  localparam int KW = cht_pkg::KEY_W;
  localparam int SW = cht_pkg::SLOT_W;
  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] LINK_NULL = '1;
  localparam logic [LW-1:0] FREE_RST  = (BUCKETS < SLOTS) ? LW'(BUCKETS) : LINK_NULL;

  typedef struct packed {
    logic          vld;
    logic [LW-1:0] link;
    logic [KW-1:0] key;
  } entry_t;

  function automatic logic is_null(input logic [LW-1:0] l);
    return l >= LW'(SLOTS);
  endfunction

  entry_t mem [SLOTS];
  entry_t rd_q, wdata, e;
  logic           we, re;
  logic [IW-1:0]  waddr, raddr;

  cht_pkg::back_state_e state_q, state_d;
  cht_pkg::cmd_t        cmd_q, cmd_d;
  logic [LW-1:0]        loc_q, loc_d, prev_q, prev_d, cell_q, cell_d, free_q, free_d;
  logic [LW-1:0]        res_loc_q, res_loc_d, init_link;
  logic [cht_pkg::ST_W-1:0] res_st_q, res_st_d;
  entry_t               pent_q, pent_d;
  logic [CW-1:0]        steps_q, steps_d, steps_nx;
  logic [IW-1:0]        init_q, init_d;
  logic                 out_vld_q, out_vld_d;
  cht_pkg::out_word_t   out_q, out_d;

  assign e           = rd_q;
  assign steps_nx    = steps_q + CW'(1);
  assign init_busy_o = (state_q == cht_pkg::B_INIT);
  assign empty_o     = !out_vld_q;
  assign out_word_o  = out_q;

  // Primary cells and the last overflow cell end in null; others chain forward.
  always_comb begin
    if (int'(init_q) < BUCKETS || int'(init_q) + 1 >= SLOTS) begin
      init_link = LINK_NULL;
    end else begin
      init_link = LW'(init_q) + LW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    loc_d     = loc_q;
    prev_d    = prev_q;
    cell_d    = cell_q;
    free_d    = free_q;
    res_loc_d = res_loc_q;
    res_st_d  = res_st_q;
    pent_d    = pent_q;
    steps_d   = steps_q;
    init_d    = init_q;
    out_vld_d = out_vld_q && !pop_i;
    out_d     = out_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    cmd_pop_o = 1'b0;
    case (state_q)
      cht_pkg::B_INIT: begin
        we    = 1'b1;
        waddr = init_q;
        wdata = '{vld: 1'b0, link: init_link, key: '0};
        if (init_q == IW'(SLOTS - 1)) begin
          state_d = cht_pkg::B_IDLE;
        end else begin
          init_d = init_q + IW'(1);
        end
      end
      cht_pkg::B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          loc_d     = LW'(cmd_i.home);
          prev_d    = LINK_NULL;
          steps_d   = '0;
          if (cmd_i.bad) begin
            res_st_d = (cmd_i.req == cht_pkg::REQ_INSERT) ? cht_pkg::ST_FULL : cht_pkg::ST_MISS;
            state_d  = cht_pkg::B_RESP;
          end else begin
            re    = 1'b1;
            raddr = IW'(cmd_i.home);
            state_d = (cmd_i.req == cht_pkg::REQ_INSERT) ? cht_pkg::B_IHOME : cht_pkg::B_SCHK;
          end
        end
      end
      cht_pkg::B_IHOME: begin
        if (!e.vld) begin
          // Keep the link so a chain hanging off this bucket stays attached.
          we        = 1'b1;
          waddr     = loc_q[IW-1:0];
          wdata     = '{vld: 1'b1, link: e.link, key: cmd_q.key};
          res_st_d  = cht_pkg::ST_OK;
          res_loc_d = loc_q;
          state_d   = cht_pkg::B_RESP;
        end else if (is_null(free_q)) begin
          res_st_d = cht_pkg::ST_FULL;
          state_d  = cht_pkg::B_RESP;
        end else begin
          cell_d  = free_q;
          re      = 1'b1;
          raddr   = free_q[IW-1:0];
          state_d = cht_pkg::B_ICELL;
        end
      end
      cht_pkg::B_ICELL: begin
        // Pop the free head, fill it, then walk to the chain tail from home.
        free_d  = e.link;
        we      = 1'b1;
        waddr   = cell_q[IW-1:0];
        wdata   = '{vld: 1'b1, link: LINK_NULL, key: cmd_q.key};
        re      = 1'b1;
        raddr   = loc_q[IW-1:0];
        steps_d = '0;
        state_d = cht_pkg::B_IWALK;
      end
      cht_pkg::B_IWALK: begin
        if (steps_q < CW'(SLOTS) && !is_null(e.link)) begin
          loc_d   = e.link;
          steps_d = steps_nx;
          re      = 1'b1;
          raddr   = e.link[IW-1:0];
        end else begin
          we        = 1'b1;
          waddr     = loc_q[IW-1:0];
          wdata     = '{vld: e.vld, link: cell_q, key: e.key};
          res_st_d  = cht_pkg::ST_OK;
          res_loc_d = cell_q;
          state_d   = cht_pkg::B_RESP;
        end
      end
      cht_pkg::B_SCHK: begin
        if (e.vld && e.key == cmd_q.key) begin
          res_st_d  = cht_pkg::ST_OK;
          res_loc_d = loc_q;
          state_d   = cht_pkg::B_RESP;
          if (cmd_q.req == cht_pkg::REQ_DELETE) begin
            we = 1'b1;
            if (is_null(prev_q)) begin
              waddr = loc_q[IW-1:0];
              wdata = '{vld: 1'b0, link: e.link, key: e.key};
            end else begin
              // Unlink from the predecessor; the freed cell is pushed next cycle.
              waddr   = prev_q[IW-1:0];
              wdata   = '{vld: pent_q.vld, link: e.link, key: pent_q.key};
              state_d = cht_pkg::B_DFREE;
            end
          end
        end else begin
          prev_d  = loc_q;
          pent_d  = e;
          loc_d   = e.link;
          steps_d = steps_nx;
          if (steps_nx < CW'(SLOTS) && !is_null(e.link)) begin
            re    = 1'b1;
            raddr = e.link[IW-1:0];
          end else begin
            res_st_d = cht_pkg::ST_MISS;
            state_d  = cht_pkg::B_RESP;
          end
        end
      end
      cht_pkg::B_DFREE: begin
        we      = 1'b1;
        waddr   = loc_q[IW-1:0];
        wdata   = '{vld: 1'b0, link: free_q, key: e.key};
        free_d  = loc_q;
        state_d = cht_pkg::B_RESP;
      end
      cht_pkg::B_RESP: begin
        if (!out_vld_q || pop_i) begin
          out_vld_d        = 1'b1;
          out_d.status     = res_st_q;
          out_d.slot_index = (res_st_q == cht_pkg::ST_OK) ? SW'(res_loc_q[IW-1:0]) : '0;
          state_d          = cht_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cht_pkg::B_INIT;
      free_q    <= FREE_RST;
      init_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      init_q    <= init_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    loc_q     <= loc_d;
    prev_q    <= prev_d;
    cell_q    <= cell_d;
    res_loc_q <= res_loc_d;
    res_st_q  <= res_st_d;
    pent_q    <= pent_d;
    steps_q   <= steps_d;
    out_q     <= out_d;
  end

  `include "cursor_hash_table_engine_core_assert.svh"

  `CHT_ASSERT_IMPL(a_free_ovf, clk_i, rst_ni, !is_null(free_q), int'(free_q) >= BUCKETS, "free list head points into the primary area")
  `CHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_vld_q && !pop_i, out_vld_q && $stable(out_q), "waiting result changed before pop")

endmodule
